[src/srtf_pkg.sv]
// ============================================================================
// srtf_pkg - shared types and constants for the SRTF scheduler
// Field widths of the request and result words, and the command and
// status bundles that pass between the controller and the datapath.
// ============================================================================
package srtf_pkg;

    // Widths of the request and result word fields.
    localparam int REQ_TYPE_W   = 1;
    localparam int SLOT_FIELD_W = 4;
    localparam int BURST_FIELD_W = 16;
    localparam int TICK_W       = 32;

    // Request type codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_ARRIVAL = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic arrive;      // accepted arrival word: load the slot if free and the burst is nonzero
        logic rd_cur;      // read remaining time of the running slot
        logic scan_start;  // clear the scan index
        logic scan_step;   // read remaining time at the scan index, advance
        logic cmp_init;    // seed the best candidate with the running slot
        logic cmp_step;    // compare the last read slot against the best
        logic rd_fst;      // read first service tick of the best slot
        logic commit;      // serve the best slot and load the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;   // scan index points at the last slot
        logic out_free;    // result register can take a new word
    } t_dp_sts;

endpackage : srtf_pkg

[src/srtf_req_if.sv]
// ============================================================================
// srtf_req_if - request channel of the SRTF scheduler
// Valid/ready channel that carries arrival and tick words.
// ============================================================================
interface srtf_req_if;
    import srtf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [REQ_TYPE_W-1:0]    req_type;
    logic [SLOT_FIELD_W-1:0]  job_slot;
    logic [BURST_FIELD_W-1:0] burst_length;

    modport source (output valid, output req_type, output job_slot,
                    output burst_length, input ready);
    modport sink   (input valid, input req_type, input job_slot,
                    input burst_length, output ready);

endinterface : srtf_req_if

[src/srtf_res_if.sv]
// ============================================================================
// srtf_res_if - result channel of the SRTF scheduler
// Valid/ready channel that carries one result word per tick.
// ============================================================================
interface srtf_res_if;
    import srtf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SLOT_FIELD_W-1:0] run_slot;
    logic                    idle;
    logic                    first_run;
    logic                    finished;
    logic [TICK_W-1:0]       start_tick;
    logic [TICK_W-1:0]       end_tick;

    modport source (output valid, output run_slot, output idle, output first_run,
                    output finished, output start_tick, output end_tick,
                    input ready);
    modport sink   (input valid, input run_slot, input idle, input first_run,
                    input finished, input start_tick, input end_tick,
                    output ready);

endinterface : srtf_res_if

[src/srtf_preemptive_scheduler_core.sv]
// ============================================================================
// srtf_preemptive_scheduler_core - preemptive SRTF job scheduler
// Top level: request and result channels, controller and datapath.
// ============================================================================
// The block keeps NUM_SLOTS job slots. An arrival word with a nonzero burst
// loads a free slot with that burst length; it gives no result. A tick word
// picks the job to run under shortest-remaining-time-first rules, serves it
// for one tick and returns exactly one result word. The time a tick takes
// is set by the search for the smallest remaining time, which walks the
// slots through the single read port of the remaining-time memory, one
// slot per cycle, followed by one read of the first-service memory and a
// commit. The result sits in an output register, so a new word is accepted
// while an earlier result still waits to be taken; a tick only stalls at
// its commit if the previous result has not yet been taken.
module srtf_preemptive_scheduler_core #(
    parameter int NUM_SLOTS  = 16,
    parameter int BURST_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    srtf_req_if.sink          i_req,
    srtf_res_if.source        o_res
);
    import srtf_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;
    logic    w_is_tick;

    // The type bit only steers the controller; the datapath sees the slot
    // and burst fields and judges whether an arrival may load its slot.
    assign w_is_tick   = (i_req.req_type == REQ_TICK);
    assign i_req.ready = w_in_ready;

    // Controller: accepts words and sequences the scan and the commit.
    srtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_is_tick  (w_is_tick),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: slot tables, minimum search and the result register.
    srtf_datapath #(
        .NUM_SLOTS  (NUM_SLOTS),
        .BURST_BITS (BURST_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_job_slot     (i_req.job_slot),
        .i_burst_length (i_req.burst_length),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_run_slot     (o_res.run_slot),
        .o_idle         (o_res.idle),
        .o_first_run    (o_res.first_run),
        .o_finished     (o_res.finished),
        .o_start_tick   (o_res.start_tick),
        .o_end_tick     (o_res.end_tick)
    );

endmodule : srtf_preemptive_scheduler_core

[src/srtf_ctrl.sv]
// ============================================================================
// srtf_ctrl - sequencing state machine of the SRTF scheduler
// Accepts request words and steps the datapath through the slot scan,
// the first-service lookup and the commit of each tick.
// ============================================================================
module srtf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_is_tick,
    output logic              o_in_ready,
    input  srtf_pkg::t_dp_sts i_sts,
    output srtf_pkg::t_dp_cmd o_cmd
);
    import srtf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_LAST   = 3'd3;
    localparam logic [2:0] S_FST    = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_is_tick) begin
                        o_cmd.rd_cur     = 1'b1;
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_INIT;
                    end else begin
                        o_cmd.arrive = 1'b1;
                    end
                end
            end
            S_INIT: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.cmp_init  = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.cmp_step  = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                o_cmd.cmp_step = 1'b1;
                n_state        = S_FST;
            end
            S_FST: begin
                o_cmd.rd_fst = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // An accepted tick always starts the scan on the next cycle.
    a_tick_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_is_tick) |=> (r_state == S_INIT))
        else $error("accepted tick did not start the scan");

    // The last compare only follows a scan cycle.
    a_last_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |-> ($past(r_state) == S_SCAN))
        else $error("last compare entered without a scan");

    // A commit never overwrites a result that is still waiting.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while result register busy");

endmodule : srtf_ctrl

[src/srtf_datapath.sv]
// ============================================================================
// srtf_datapath - slot tables, minimum search and result register
// Holds the remaining-time and first-service memories, the per-slot
// active and started bits, the running-job registers and the tick counter.
// ============================================================================
module srtf_datapath #(
    parameter int NUM_SLOTS  = 16,
    parameter int BURST_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  srtf_pkg::t_dp_cmd                      i_cmd,
    output srtf_pkg::t_dp_sts                      o_sts,
    input  logic [srtf_pkg::SLOT_FIELD_W-1:0]      i_job_slot,
    input  logic [srtf_pkg::BURST_FIELD_W-1:0]     i_burst_length,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [srtf_pkg::SLOT_FIELD_W-1:0]      o_run_slot,
    output logic                                   o_idle,
    output logic                                   o_first_run,
    output logic                                   o_finished,
    output logic [srtf_pkg::TICK_W-1:0]            o_start_tick,
    output logic [srtf_pkg::TICK_W-1:0]            o_end_tick
);
    import srtf_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Storage.
    logic [BURST_BITS-1:0] r_rem_mem [NUM_SLOTS];
    logic [TICK_W-1:0]     r_fst_mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_active;
    logic [NUM_SLOTS-1:0]  r_started;
    logic [SLOT_W-1:0]     r_cur_slot;
    logic                  r_cur_valid;
    logic [TICK_W-1:0]     r_tick;

    // Scan and selection.
    logic [SLOT_W-1:0]     r_idx;
    logic [SLOT_W-1:0]     r_rd_idx;
    logic [BURST_BITS-1:0] r_rd_data;
    logic                  r_have;
    logic [SLOT_W-1:0]     r_best;
    logic [BURST_BITS-1:0] r_best_rem;
    logic [TICK_W-1:0]     r_fst_rd;

    // Result register.
    logic                    r_out_valid;
    logic [SLOT_FIELD_W-1:0] r_out_slot;
    logic                    r_out_idle;
    logic                    r_out_first;
    logic                    r_out_finished;
    logic [TICK_W-1:0]       r_out_start;
    logic [TICK_W-1:0]       r_out_end;

    // Arrival decode.
    logic [8:0]            w_slot_ext;
    logic                  w_in_range;
    logic [SLOT_W-1:0]     w_arr_idx;
    logic [31:0]           w_burst32;
    logic [BURST_BITS-1:0] w_burst;
    logic                  w_arr_ok;

    // Compare and commit.
    logic                  w_take;
    logic                  w_seed_have;
    logic [BURST_BITS-1:0] w_new_rem;
    logic                  w_first;
    logic                  w_done;
    logic [TICK_W-1:0]     w_start;
    logic [TICK_W-1:0]     w_tick_nx;
    logic [8:0]            w_best_ext;
    logic                  w_serve;

    assign w_slot_ext = 9'(i_job_slot);
    assign w_in_range = (w_slot_ext < 9'(NUM_SLOTS));
    assign w_arr_idx  = w_slot_ext[SLOT_W-1:0];
    assign w_burst32  = 32'(i_burst_length);
    assign w_burst    = w_burst32[BURST_BITS-1:0];
    assign w_arr_ok   = i_cmd.arrive && w_in_range && !r_active[w_arr_idx]
                        && (w_burst != '0);

    assign w_take      = r_active[r_rd_idx] && (!r_have || (r_rd_data < r_best_rem));
    assign w_seed_have = r_cur_valid && r_active[r_cur_slot];

    assign w_serve    = i_cmd.commit && r_have;
    assign w_new_rem  = r_best_rem - 1'b1;
    assign w_first    = !r_started[r_best];
    assign w_done     = (w_new_rem == '0);
    assign w_start    = w_first ? r_tick : r_fst_rd;
    assign w_tick_nx  = r_tick + 32'd1;
    assign w_best_ext = 9'(r_best);

    assign o_sts.scan_last = (r_idx == SLOT_W'(NUM_SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Remaining-time memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_arr_ok) begin
            r_rem_mem[w_arr_idx] <= w_burst;
        end else if (w_serve) begin
            r_rem_mem[r_best] <= w_new_rem;
        end
        if (i_cmd.rd_cur) begin
            r_rd_data <= r_rem_mem[r_cur_slot];
        end else if (i_cmd.scan_step) begin
            r_rd_data <= r_rem_mem[r_idx];
        end
    end

    // First-service memory.
    always_ff @(posedge i_clk) begin
        if (w_serve && w_first) begin
            r_fst_mem[r_best] <= r_tick;
        end
        if (i_cmd.rd_fst) begin
            r_fst_rd <= r_fst_mem[r_best];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_started   <= '0;
            r_cur_slot  <= '0;
            r_cur_valid <= 1'b0;
            r_tick      <= '0;
            r_idx       <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_arr_ok) begin
                r_active[w_arr_idx]  <= 1'b1;
                r_started[w_arr_idx] <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.cmp_init) begin
                r_have <= w_seed_have;
            end else if (i_cmd.cmp_step && w_take) begin
                r_have <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_tick <= w_tick_nx;
                if (!r_have) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    if (w_first) begin
                        r_started[r_best] <= 1'b1;
                    end
                    if (w_done) begin
                        r_active[r_best] <= 1'b0;
                        r_cur_valid      <= 1'b0;
                    end else begin
                        r_cur_slot  <= r_best;
                        r_cur_valid <= 1'b1;
                    end
                end
            end
            r_out_valid <= i_cmd.commit || (r_out_valid && !i_out_ready);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_rd_idx <= r_idx;
        end
        if (i_cmd.cmp_init) begin
            r_best     <= r_cur_slot;
            r_best_rem <= r_rd_data;
        end else if (i_cmd.cmp_step && w_take) begin
            r_best     <= r_rd_idx;
            r_best_rem <= r_rd_data;
        end
        if (i_cmd.commit) begin
            r_out_slot     <= r_have ? w_best_ext[SLOT_FIELD_W-1:0] : '0;
            r_out_idle     <= !r_have;
            r_out_first    <= r_have && w_first;
            r_out_finished <= r_have && w_done;
            r_out_start    <= (r_have && w_done) ? w_start : '0;
            r_out_end      <= (r_have && w_done) ? w_tick_nx : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_run_slot   = r_out_slot;
    assign o_idle       = r_out_idle;
    assign o_first_run  = r_out_first;
    assign o_finished   = r_out_finished;
    assign o_start_tick = r_out_start;
    assign o_end_tick   = r_out_end;

    // The running job always sits in an active slot.
    a_cur_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_active[r_cur_slot])
        else $error("running job in an inactive slot");

    // A completion is never reported on an idle tick.
    a_finish_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_finished) |-> !r_out_idle)
        else $error("finished flag on an idle tick");

endmodule : srtf_datapath

[tb/testbench.sv]
// ============================================================================
// testbench - self-checking bench for srtf_preemptive_scheduler_core
// Drives arrival and tick words, predicts each tick's result word with a
// scheduler model of its own, and compares every result field by field.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import srtf_pkg::*;

    localparam int SLOTS        = 16;
    localparam int RANDOM_WORDS = 600;
    localparam int CYCLE_LIMIT  = 400000;

    // Flow-control pace of a stretch of the run. Each request word carries
    // the pace it is sent under, and the result side follows along.
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC_GAPS,
        PACE_SNK_STALLS,
        PACE_BOTH
    } t_pace;

    // One request word as queued for the driver.
    typedef struct {
        logic [REQ_TYPE_W-1:0]    kind;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [BURST_FIELD_W-1:0] burst;
        bit                       wait_for_drain;
        t_pace                    pace;
    } t_req_word;

    // One result word as the scheduler should report it.
    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] run_slot;
        logic                    idle;
        logic                    first_run;
        logic                    finished;
        logic [TICK_W-1:0]       start_tick;
        logic [TICK_W-1:0]       end_tick;
    } t_tick_report;

    // Percent of cycles in which the sender holds back, and in which the
    // receiver refuses a result, for each pace.
    int src_gap_pct   [4] = '{0, 72, 0, 19};
    int snk_stall_pct [4] = '{0, 0, 72, 19};

    logic i_clk;
    logic i_rst_n;

    srtf_req_if req_bus ();
    srtf_res_if res_bus ();

    srtf_preemptive_scheduler_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // 8 ns clock period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Scheduler model. It mirrors the job table: how many ticks each slot
    // still needs, whether the slot holds a job, whether that job has been
    // served yet and at which tick it was first served, plus the job that
    // currently owns the processor and the running tick counter.
    // ------------------------------------------------------------------------
    logic [BURST_FIELD_W-1:0] job_left       [SLOTS] = '{default: '0};
    logic                     job_live       [SLOTS] = '{default: 1'b0};
    logic                     job_begun      [SLOTS] = '{default: 1'b0};
    logic [TICK_W-1:0]        job_first_tick [SLOTS] = '{default: '0};
    logic [SLOT_FIELD_W-1:0]  running_slot = '0;
    logic                     running_ok   = 1'b0;
    logic [TICK_W-1:0]        sched_time   = '0;

    t_req_word    word_queue [$];
    t_tick_report expected_reports [$];
    t_req_word    in_flight;
    t_tick_report due_report;
    t_pace        pace_now = PACE_FREE;
    t_pace        fill_pace;
    bit           hold_next;
    int           mismatches = 0;
    int           cycle_count = 0;

    // Applies one accepted word to the model. An arrival only loads a free
    // slot with a nonzero burst. A tick keeps the running job unless some
    // live job needs strictly fewer ticks; the scan runs from slot 0 upward
    // with a strict compare, so ties go to the lowest slot.
    task automatic predict_schedule(input t_req_word w);
        t_tick_report            rep;
        logic                    found;
        logic [SLOT_FIELD_W-1:0] pick;
        logic [BURST_FIELD_W-1:0] pick_left;

        rep       = '0;
        found     = running_ok && job_live[running_slot];
        pick      = running_slot;
        pick_left = job_left[running_slot];

        if (w.kind == REQ_ARRIVAL) begin
            if (!job_live[w.slot] && w.burst != '0) begin
                job_left[w.slot]  = w.burst;
                job_live[w.slot]  = 1'b1;
                job_begun[w.slot] = 1'b0;
            end
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                if (job_live[i] && (!found || job_left[i] < pick_left)) begin
                    found     = 1'b1;
                    pick      = SLOT_FIELD_W'(i);
                    pick_left = job_left[i];
                end
            end
            if (!found) begin
                // Nothing ready: an idle tick still moves time forward.
                running_ok = 1'b0;
                rep.idle   = 1'b1;
                sched_time = sched_time + 1;
            end else begin
                rep.run_slot = pick;
                if (!job_begun[pick]) begin
                    job_begun[pick]      = 1'b1;
                    job_first_tick[pick] = sched_time;
                    rep.first_run        = 1'b1;
                end
                job_left[pick] = job_left[pick] - 1'b1;
                sched_time     = sched_time + 1;
                if (job_left[pick] == '0) begin
                    // The slot frees up and the next tick chooses afresh.
                    job_live[pick] = 1'b0;
                    running_ok     = 1'b0;
                    rep.finished   = 1'b1;
                    rep.start_tick = job_first_tick[pick];
                    rep.end_tick   = sched_time;
                end else begin
                    running_slot = pick;
                    running_ok   = 1'b1;
                end
            end
            expected_reports.push_back(rep);
        end
    endtask

    task automatic push_arrival(input logic [SLOT_FIELD_W-1:0] slot,
                                input logic [BURST_FIELD_W-1:0] burst);
        word_queue.push_back('{REQ_ARRIVAL, slot, burst, hold_next, fill_pace});
        hold_next = 1'b0;
    endtask

    task automatic push_tick();
        // Slot and burst are don't-care on a tick, so they carry noise.
        word_queue.push_back('{REQ_TICK, SLOT_FIELD_W'($urandom),
                               BURST_FIELD_W'($urandom), hold_next, fill_pace});
        hold_next = 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [TICK_W-1:0] want,
                                 input logic [TICK_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. A word is held until the block takes it; the model is updated
    // at the edge of acceptance. A word flagged to wait for a drain is held
    // back until every predicted result has been taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid        <= 1'b0;
            req_bus.req_type     <= REQ_ARRIVAL;
            req_bus.job_slot     <= '0;
            req_bus.burst_length <= '0;
        end else if (!req_bus.valid || req_bus.ready) begin
            if (req_bus.valid) begin
                predict_schedule(in_flight);
            end
            if (word_queue.size() != 0
                    && !(word_queue[0].wait_for_drain && expected_reports.size() != 0)
                    && $urandom_range(99) >= src_gap_pct[word_queue[0].pace]) begin
                in_flight             = word_queue.pop_front();
                pace_now             <= in_flight.pace;
                req_bus.valid        <= 1'b1;
                req_bus.req_type     <= in_flight.kind;
                req_bus.job_slot     <= in_flight.slot;
                req_bus.burst_length <= in_flight.burst;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Every result word taken is matched against the oldest
    // prediction; the ready line stalls at random according to the pace.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result word with none predicted: run_slot %0d idle %0b",
                           res_bus.run_slot, res_bus.idle);
                    mismatches++;
                end else begin
                    due_report = expected_reports.pop_front();
                    compare_field("run_slot", TICK_W'(due_report.run_slot),
                                  TICK_W'(res_bus.run_slot));
                    compare_field("idle", TICK_W'(due_report.idle),
                                  TICK_W'(res_bus.idle));
                    compare_field("first_run", TICK_W'(due_report.first_run),
                                  TICK_W'(res_bus.first_run));
                    compare_field("finished", TICK_W'(due_report.finished),
                                  TICK_W'(res_bus.finished));
                    compare_field("start_tick", due_report.start_tick, res_bus.start_tick);
                    compare_field("end_tick", due_report.end_tick, res_bus.end_tick);
                end
            end
            res_bus.ready <= ($urandom_range(99) >= snk_stall_pct[pace_now]);
        end
    end

    // A hung handshake must not hold the run forever.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** srtf_preemptive_scheduler_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        int                       made;
        int                       seg_len;
        int                       tick_pct;
        int                       roll;
        logic [BURST_FIELD_W-1:0] burst;

        i_rst_n              = 1'b0;
        hold_next            = 1'b0;
        fill_pace            = PACE_FREE;

        // Directed opening. A tick on an empty table is idle, and so is one
        // after an arrival with zero burst, which must be dropped.
        push_tick();
        push_arrival(4'd0, 16'd0);
        push_tick();
        // A second arrival into a live slot must not replace its job.
        push_arrival(4'd5, 16'd3);
        push_arrival(4'd5, 16'd1);
        push_tick();
        // Slot 9 only ties the running job and must not preempt it; slot 2
        // is strictly shorter and takes over, finishing on its first tick.
        push_arrival(4'd9, 16'd2);
        push_arrival(4'd2, 16'd1);
        push_tick();
        // With nobody running, slots 5 and 9 tie and the lower one wins.
        push_tick();
        push_tick();
        push_tick();
        push_tick();
        push_tick();
        // Tie between the two end slots, then run both out and go idle.
        push_arrival(4'd15, 16'd4);
        push_arrival(4'd0, 16'd4);
        repeat (9) push_tick();

        // Random part: four paces, each a string of segments with their own
        // mix of ticks and arrivals, so the table fills up and drains again.
        for (int p = 0; p < 4; p++) begin
            fill_pace = t_pace'(p);
            hold_next = 1'b1;
            made      = 0;
            while (made < RANDOM_WORDS / 4) begin
                tick_pct = $urandom_range(85, 25);
                seg_len  = $urandom_range(40, 15);
                for (int k = 0; k < seg_len && made < RANDOM_WORDS / 4; k++) begin
                    if ($urandom_range(99) < tick_pct) begin
                        push_tick();
                    end else begin
                        roll = $urandom_range(99);
                        if (roll < 2) begin
                            burst = '0;
                        end else if (roll < 85) begin
                            burst = BURST_FIELD_W'($urandom_range(6, 1));
                        end else begin
                            burst = BURST_FIELD_W'($urandom_range(40, 7));
                        end
                        push_arrival(SLOT_FIELD_W'($urandom_range(SLOTS - 1)), burst);
                    end
                    made++;
                end
            end
        end

        // Closing loads with wide bursts exercise the upper bits of the compare.
        hold_next = 1'b1;
        for (int s = 0; s < SLOTS; s++) begin
            if (s == SLOTS - 1) begin
                push_arrival(SLOT_FIELD_W'(s), 16'hFFFF);
            end else begin
                push_arrival(SLOT_FIELD_W'(s), BURST_FIELD_W'($urandom_range(16'hFFFF, 1)));
            end
        end
        repeat (10) push_tick();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_queue.size() != 0 || req_bus.valid || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
        // Give a stray extra result time to show up.
        repeat (SLOTS + 8) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("** srtf_preemptive_scheduler_core: PASSED **");
        end else begin
            $display("** srtf_preemptive_scheduler_core: FAILED **");
        end
        $finish;
    end

endmodule : testbench
